// File: src/wfr_pkg.sv
package wfr_pkg;

    // Sizes
    localparam int TAPS           = 32;
    localparam int TAP_W          = 5;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 18;
    localparam int COEF_W         = COEF_FRAC_BITS + 1;
    localparam int PROD_W         = SAMPLE_BITS + COEF_W + 1;
    localparam int ACC_W          = PROD_W + TAP_W;
    localparam int Q_W            = ACC_W - COEF_FRAC_BITS;
    localparam int UPC_W          = 3;

    // Request kinds carried on s_tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Saturation limits on the shifted sum
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

    typedef logic [UPC_W-1:0] upc_t;

    // Microprogram addresses
    localparam upc_t UPC_IDLE   = 3'd0;
    localparam upc_t UPC_MAC    = 3'd1;
    localparam upc_t UPC_DRAIN0 = 3'd2;
    localparam upc_t UPC_DRAIN1 = 3'd3;
    localparam upc_t UPC_EMIT   = 3'd4;
    localparam upc_t UPC_LAST   = UPC_EMIT;

    // Jump conditions
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_SAMPLE,
        JC_TAPS_LEFT,
        JC_OUT_BUSY
    } jcond_t;

    // One microcode word
    typedef struct packed {
        logic   take_in;
        logic   rd_issue;
        logic   emit;
        jcond_t jcond;
        upc_t   target;
    } uword_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic             ring_wr;
        logic             coef_wr;
        logic             clr_acc;
        logic             rd_issue;
        logic [TAP_W-1:0] tap;
        logic             emit;
    } ctrl_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] filtered;
        logic                   clipped;
    } result_t;

    // Control store
    function automatic uword_t urom(upc_t pc);
        uword_t w;
        w = '{take_in: 1'b0, rd_issue: 1'b0, emit: 1'b0, jcond: JC_ALWAYS, target: UPC_IDLE};
        case (pc)
            UPC_IDLE: begin
                w.take_in = 1'b1;
                w.jcond   = JC_NO_SAMPLE;
                w.target  = UPC_IDLE;
            end
            UPC_MAC: begin
                w.rd_issue = 1'b1;
                w.jcond    = JC_TAPS_LEFT;
                w.target   = UPC_MAC;
            end
            UPC_DRAIN0: w.jcond = JC_NEXT;
            UPC_DRAIN1: w.jcond = JC_NEXT;
            UPC_EMIT: begin
                w.emit   = 1'b1;
                w.jcond  = JC_OUT_BUSY;
                w.target = UPC_EMIT;
            end
            default: w.jcond = JC_ALWAYS;
        endcase
        return w;
    endfunction

    // Floor shift by the coefficient fraction, then saturate
    function automatic result_t sat_shift(logic signed [ACC_W-1:0] acc);
        logic signed [Q_W-1:0] q;
        result_t               r;
        q = Q_W'(acc >>> COEF_FRAC_BITS);
        if (q > Q_MAX) begin
            r.filtered = Q_MAX[SAMPLE_BITS-1:0];
            r.clipped  = 1'b1;
        end else if (q < Q_MIN) begin
            r.filtered = Q_MIN[SAMPLE_BITS-1:0];
            r.clipped  = 1'b1;
        end else begin
            r.filtered = q[SAMPLE_BITS-1:0];
            r.clipped  = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: src/wfr_useq.sv
module wfr_useq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_kind,
    input  logic          out_free,
    output logic          s_tready,
    output wfr_pkg::ctrl_t ctrl
);

    wfr_pkg::upc_t                upc_reg, upc_next;
    logic [wfr_pkg::TAP_W-1:0]    tap_reg, tap_next;
    wfr_pkg::uword_t              uw;
    logic                         accept;
    logic                         jump;

    assign uw     = wfr_pkg::urom(upc_reg);
    assign accept = s_tvalid && uw.take_in;

    // Jump condition select
    always_comb begin
        case (uw.jcond)
            wfr_pkg::JC_NEXT:      jump = 1'b0;
            wfr_pkg::JC_ALWAYS:    jump = 1'b1;
            wfr_pkg::JC_NO_SAMPLE: jump = !(accept && s_kind == wfr_pkg::KIND_SAMPLE);
            wfr_pkg::JC_TAPS_LEFT: jump = tap_reg != wfr_pkg::TAP_W'(wfr_pkg::TAPS - 1);
            wfr_pkg::JC_OUT_BUSY:  jump = !out_free;
            default:               jump = 1'b0;
        endcase
    end

    // Next step and tap count
    always_comb begin
        if (jump) begin
            upc_next = uw.target;
        end else if (upc_reg == wfr_pkg::UPC_LAST) begin
            upc_next = wfr_pkg::UPC_IDLE;
        end else begin
            upc_next = upc_reg + wfr_pkg::UPC_W'(1);
        end
        if (uw.take_in) begin
            tap_next = '0;
        end else if (uw.rd_issue) begin
            tap_next = tap_reg + wfr_pkg::TAP_W'(1);
        end else begin
            tap_next = tap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= wfr_pkg::UPC_IDLE;
            tap_reg <= '0;
        end else begin
            upc_reg <= upc_next;
            tap_reg <= tap_next;
        end
    end

    // Datapath controls
    always_comb begin
        s_tready      = uw.take_in;
        ctrl.ring_wr  = accept && s_kind == wfr_pkg::KIND_SAMPLE;
        ctrl.coef_wr  = accept && s_kind == wfr_pkg::KIND_COEF;
        ctrl.clr_acc  = uw.take_in;
        ctrl.rd_issue = uw.rd_issue;
        ctrl.tap      = tap_reg;
        ctrl.emit     = uw.emit && out_free;
    end

endmodule

// File: src/wfr_datapath.sv
module wfr_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wfr_pkg::ctrl_t                      ctrl,
    input  logic                                offset_mode,
    input  logic [wfr_pkg::SAMPLE_BITS-1:0]     sample,
    input  logic [wfr_pkg::TAP_W-1:0]           coef_index,
    input  logic [wfr_pkg::COEF_W-1:0]          coef_value,
    output wfr_pkg::result_t                    result
);

    // Sample ring and window coefficients
    logic [wfr_pkg::SAMPLE_BITS-1:0] ring_mem [wfr_pkg::TAPS];
    logic [wfr_pkg::COEF_W-1:0]      coef_mem [wfr_pkg::TAPS];
    logic [wfr_pkg::TAPS-1:0]        ring_vld_reg;

    logic [wfr_pkg::TAP_W-1:0]         wp_reg;
    logic [wfr_pkg::TAP_W-1:0]         rd_addr;
    logic [wfr_pkg::SAMPLE_BITS-1:0]   ring_rd_reg;
    logic                              ring_hit_reg;
    logic [wfr_pkg::COEF_W-1:0]        coef_rd_reg;
    logic                              rd_vld_reg;
    logic signed [wfr_pkg::SAMPLE_BITS-1:0] smp;
    logic signed [wfr_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_vld_reg;
    logic signed [wfr_pkg::ACC_W-1:0]  acc_reg;

    // Tap address: backwards from the previous sample, or forwards from half a ring back
    always_comb begin
        if (offset_mode) begin
            rd_addr = wp_reg + ctrl.tap - wfr_pkg::TAP_W'(wfr_pkg::TAPS / 2);
        end else begin
            rd_addr = wp_reg - ctrl.tap - wfr_pkg::TAP_W'(1);
        end
    end

    // Memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (ctrl.ring_wr) begin
            ring_mem[wp_reg] <= sample;
        end
        if (ctrl.coef_wr) begin
            coef_mem[coef_index] <= coef_value;
        end
        ring_rd_reg  <= ring_mem[rd_addr];
        coef_rd_reg  <= coef_mem[ctrl.tap];
        ring_hit_reg <= ring_vld_reg[rd_addr];
    end

    // Entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg <= '0;
        end else if (ctrl.ring_wr) begin
            ring_vld_reg[wp_reg] <= 1'b1;
        end
    end

    // Write position advances when the result register loads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
        end else if (ctrl.emit) begin
            wp_reg <= wp_reg + wfr_pkg::TAP_W'(1);
        end
    end

    assign smp = ring_hit_reg ? $signed(ring_rd_reg) : '0;

    // Multiply then accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= ctrl.rd_issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= smp * $signed({1'b0, coef_rd_reg});
        if (ctrl.clr_acc) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + wfr_pkg::ACC_W'(prod_reg);
        end
    end

    assign result = wfr_pkg::sat_shift(acc_reg);

endmodule

// File: src/windowed_fir_ring_filter_core.sv
// 32-tap windowed FIR over a ring of signed 24-bit samples. A request with
// s_tuser = 1 loads one unsigned Q1.18 window coefficient and returns nothing;
// the block stays ready. A request with s_tuser = 0 stores the sample, sums the 32
// coefficient-sample products, and returns the sum shifted right 18 (toward
// minus infinity), saturated to 24 bits, with m_tuser set when it clipped.
// A sample holds the block through these steps, the last of which loads the
// result register: one acceptance step, 32 steps of the single
// multiply-accumulate unit (one tap per cycle, set by the one read port of each
// tap memory), two steps to drain the read and multiply registers, one to load
// the result. A result that is not yet
// taken holds the sequencer in its load step. The sample ring reads as zero
// after reset; every coefficient must be loaded before the first sample.
// offset_mode = 0 reads taps backwards from the previous sample, 1 reads
// forwards from half a ring behind the write position.
module windowed_fir_ring_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_wdata,    // offset_mode
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,      // sample[23:0], coef_index[28:24], coef_value[47:29]
    input  logic        s_tuser,      // kind
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // filtered[23:0]
    output logic        m_tuser       // clipped
);

    wfr_pkg::ctrl_t   ctrl;
    wfr_pkg::result_t result;
    logic             offset_mode_reg;
    logic             out_free;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;
    logic             m_tuser_reg;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            offset_mode_reg <= cfg_wdata;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    wfr_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .out_free (out_free),
        .s_tready (s_tready),
        .ctrl     (ctrl)
    );

    wfr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .offset_mode (offset_mode_reg),
        .sample      (s_tdata[23:0]),
        .coef_index  (s_tdata[28:24]),
        .coef_value  (s_tdata[47:29]),
        .result      (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            m_tdata_reg <= result.filtered;
            m_tuser_reg <= result.clipped;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // No tap read while requests are being taken
    a_ready_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && ctrl.rd_issue))
        else $error("tap read issued while accepting requests");

    // A sample request starts the sum and blocks further requests
    a_sample_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == wfr_pkg::KIND_SAMPLE) |=> !s_tready)
        else $error("ready stayed high after a sample request");

    // A coefficient load leaves the block ready
    a_coef_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == wfr_pkg::KIND_COEF) |=> s_tready)
        else $error("coefficient load left the block busy");

    // A new result only comes from the load step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ctrl.emit))
        else $error("result appeared without a load step");

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wfr_pkg::*;

    // Cycles without any request or result before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Settle time in wait_idle, longer than a sample takes to reach the result register
    localparam int SETTLE_CYCLES = 40;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);
    localparam logic [COEF_W-1:0] COEF_TOP = '1;
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Tracks the ring, the window and the mode; holds the sums still owed
    class fir_scoreboard;
        logic [SAMPLE_BITS-1:0] ring [TAPS];
        logic [COEF_W-1:0]      coefs [TAPS];
        logic [TAP_W-1:0]       wpos;
        logic                   offset_mode;
        result_t                sums_owed [$];
        int                     mismatches;

        function new();
            foreach (ring[i]) begin
                ring[i]  = '0;
                coefs[i] = '0;
            end
            wpos        = '0;
            offset_mode = 1'b0;
            mismatches  = 0;
        endfunction

        // Update state for an accepted request and queue the windowed sum
        function void note_request(logic kind, logic [47:0] data);
            logic signed [63:0] acc;
            logic signed [63:0] smp;
            logic signed [63:0] cf;
            logic signed [63:0] q;
            logic signed [63:0] hi;
            logic signed [63:0] lo;
            logic [TAP_W-1:0]   idx;
            result_t            r;
            int                 i;
            if (kind == KIND_COEF) begin
                coefs[data[28:24]] = data[47:29];
                return;
            end
            ring[wpos] = data[SAMPLE_BITS-1:0];
            acc = '0;
            for (i = 0; i < TAPS; i++) begin
                // wraps modulo the ring size through the index width
                if (offset_mode)
                    idx = TAP_W'(wpos + i - TAPS / 2);
                else
                    idx = TAP_W'(wpos - 1 - i);
                smp = {{(64-SAMPLE_BITS){ring[idx][SAMPLE_BITS-1]}}, ring[idx]};
                cf  = {{(64-COEF_W){1'b0}}, coefs[i]};
                acc = acc + smp * cf;
            end
            q  = acc >>> COEF_FRAC_BITS;
            hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            if (q > hi) begin
                r.filtered = hi[SAMPLE_BITS-1:0];
                r.clipped  = 1'b1;
            end else if (q < lo) begin
                r.filtered = lo[SAMPLE_BITS-1:0];
                r.clipped  = 1'b1;
            end else begin
                r.filtered = q[SAMPLE_BITS-1:0];
                r.clipped  = 1'b0;
            end
            sums_owed.push_back(r);
            wpos = wpos + 1'b1;
        endfunction

        // Compare one result with the oldest sum owed
        function void check_result(logic [SAMPLE_BITS-1:0] filtered, logic clipped);
            result_t want;
            if (sums_owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result filtered=%0d clipped=%0b",
                             $realtime, $signed(filtered), clipped);
                return;
            end
            want = sums_owed.pop_front();
            if (want.filtered !== filtered || want.clipped !== clipped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch filtered exp=%0d got=%0d, clipped exp=%0b got=%0b",
                             $realtime, $signed(want.filtered), $signed(filtered),
                             want.clipped, clipped);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    bit            calm = 1'b0;
    int            quiet_cycles = 0;
    fir_scoreboard sb = new();

    windowed_fir_ring_filter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side backpressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 10);
    end

    // Watch both channels and the progress watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("windowed_fir_ring_filter_core test failed");
                $finish;
            end
        end
    end

    function automatic logic [47:0] pack_request(logic [SAMPLE_BITS-1:0] smp,
                                                 logic [TAP_W-1:0] ci,
                                                 logic [COEF_W-1:0] cv);
        return {cv, ci, smp};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int sel;
        sel = $urandom_range(15);
        case (sel)
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return '0;
            3: return '1;
            4, 5: return ($urandom_range(1) != 0) ? SAMPLE_BITS'($urandom_range(255))
                                                   : -SAMPLE_BITS'($urandom_range(255));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // regime 0: any width value, 1: small so the window sums to at most one, 2: mostly edges
    function automatic logic [COEF_W-1:0] pick_coef(int regime);
        int sel;
        sel = $urandom_range(3);
        if (regime == 0)
            return COEF_W'($urandom);
        if (regime == 1)
            return COEF_W'($urandom_range(COEF_ONE / TAPS));
        case (sel)
            0: return '0;
            1: return COEF_ONE;
            2: return COEF_TOP;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Present one request, then wait on the clock until s_tready is seen high
    task automatic send_request(input logic kind, input logic [47:0] data);
        while (!calm && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
        send_request(KIND_SAMPLE, pack_request(smp, TAP_W'($urandom), COEF_W'($urandom)));
    endtask

    task automatic send_coef(input logic [TAP_W-1:0] ci, input logic [COEF_W-1:0] cv);
        send_request(KIND_COEF, pack_request(SAMPLE_BITS'($urandom), ci, cv));
    endtask

    // Drain all owed sums, let a trailing coefficient load finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.sums_owed.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.offset_mode = mode;
    endtask

    // Reload the whole window, starting at a random tap
    task automatic load_window(input int regime);
        int                 k;
        logic [TAP_W-1:0]   start;
        start = TAP_W'($urandom);
        for (k = 0; k < TAPS; k++)
            send_coef(TAP_W'(start + k), pick_coef(regime));
    endtask

    initial begin
        int   k;
        int   p;
        int   n;
        logic mode;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: window above one everywhere, newest sample meets last tap
        write_mode(1'b0);
        for (k = 0; k < TAPS; k++)
            send_coef(TAP_W'(k), COEF_TOP);
        send_sample('1);             // small negative sum, floor goes one further down
        send_sample(SAMPLE_BITS'(1));
        send_sample(SMP_MAX);        // positive clip
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(SMP_MIN);
        send_sample(SMP_MIN);        // negative clip
        send_sample('0);

        // Directed: half-ring offset reading
        write_mode(1'b1);
        send_coef(TAP_W'(0), '0);
        send_coef(TAP_W'(TAPS - 1), COEF_ONE);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample('1);
        send_sample(SAMPLE_BITS'(1));

        // Random phases, each with its own mode and window
        for (p = 0; p < 8; p++) begin
            calm = (p == 3);
            mode = (p < 4) ? p[0] : 1'($urandom_range(1));
            write_mode(mode);
            load_window(p % 3);
            for (n = 0; n < 70; n++) begin
                if ($urandom_range(99) < 15)
                    send_coef(TAP_W'($urandom), pick_coef(p % 3));
                else
                    send_sample(pick_sample());
            end
        end
        calm = 1'b0;

        wait_idle();
        if (sb.mismatches == 0 && sb.sums_owed.size() == 0)
            $display("windowed_fir_ring_filter_core test passed");
        else
            $display("windowed_fir_ring_filter_core test failed");
        $finish;
    end

endmodule

// File: windowed_fir_ring_filter_core.f
src/wfr_pkg.sv
src/wfr_useq.sv
src/wfr_datapath.sv
src/windowed_fir_ring_filter_core.sv
dv/tb.sv
